/* rtl/core/ssq_pkg.sv */
// ssq_pkg: shared types and constants for the stable sorted priority queue
// used by ssq_cell and stable_sorted_priority_queue; no dependencies
`timescale 1ns / 1ps

package ssq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int VAL_W = 16;
  localparam int PRI_W = 4;
  localparam int ST_W  = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             opcode;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] popped_value;
    logic [PRI_W-1:0] popped_priority;
  } out_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
  } entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t fresh;
  } cell_ctrl_t;

endpackage

/* rtl/core/ssq_cell.sv */
// ssq_cell: one slot of the sorted row, holds one entry and trades with neighbours
// depends on ssq_pkg
`timescale 1ns / 1ps

module ssq_cell (
  input  logic                clk,
  input  ssq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  logic                keep_left,
  input  ssq_pkg::entry_t     left,
  input  ssq_pkg::entry_t     right,
  output logic                keep,
  output ssq_pkg::entry_t     data
);

  ssq_pkg::entry_t data_next;

  // entry stays put when it ranks equal or above the incoming one
  assign keep = occ && (data.prio >= ctrl.fresh.prio);

  always_comb begin
    data_next = data;
    if (ctrl.pop) begin
      data_next = right;
    end else if (ctrl.push && !keep) begin
      if (keep_left) begin
        data_next = ctrl.fresh;
      end else begin
        data_next = left;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* rtl/core/stable_sorted_priority_queue.sv */
// stable_sorted_priority_queue: top level, row of ssq_cell slots plus fill count
// depends on ssq_pkg and ssq_cell
//
// usage
//   command channel: cmd carries opcode, value and priority_req; a word is
//   taken at a rising edge with start high and busy low. busy stays low, so
//   a command may be issued in every cycle.
//   result channel: one result word per command, on result with done high
//   for exactly one cycle, the cycle after the command is taken.
//   throughput 1 command per cycle: every cell compares its own priority
//   with the incoming one at once and shifts in one step.
//   push places the entry behind all entries of equal or higher priority;
//   pop returns the head. pop on empty gives status empty, push on full
//   gives status full, both leave the queue unchanged.
//   reset empties the queue (fill count to zero) and clears done; cell
//   contents are not cleared. the receiver cannot stall: a result word is
//   valid only in its done cycle.
module stable_sorted_priority_queue #(
  parameter int DEPTH = ssq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ssq_pkg::in_word_t  cmd,
  output logic               done,
  output ssq_pkg::out_word_t result
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                take;
  logic                is_full;
  logic                is_empty;
  logic                do_push;
  logic                do_pop;
  ssq_pkg::cell_ctrl_t ctrl;
  ssq_pkg::out_word_t  result_next;
  logic [DEPTH-1:0]    occ;
  logic [DEPTH-1:0]    keep;
  ssq_pkg::entry_t     data [DEPTH];

  assign busy     = 1'b0;
  assign take     = start && !busy;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign do_push  = take && (cmd.opcode == ssq_pkg::OP_PUSH) && !is_full;
  assign do_pop   = take && (cmd.opcode == ssq_pkg::OP_POP) && !is_empty;

  assign ctrl.push        = do_push;
  assign ctrl.pop         = do_pop;
  assign ctrl.fresh.value = cmd.value;
  assign ctrl.fresh.prio  = cmd.priority_req;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      ssq_pkg::entry_t left;
      ssq_pkg::entry_t right;
      logic            keep_left;

      assign occ[g] = (CW'(g) < count);

      if (g == 0) begin : g_head
        assign left      = '0;
        assign keep_left = 1'b1;
      end else begin : g_mid
        assign left      = data[g-1];
        assign keep_left = keep[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
        assign right = '0;
      end else begin : g_body
        assign right = data[g+1];
      end

      ssq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (occ[g]),
        .keep_left (keep_left),
        .left      (left),
        .right     (right),
        .keep      (keep[g]),
        .data      (data[g])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    result_next = '0;
    if (do_push) begin
      count_next = count + CW'(1);
    end else if (do_pop) begin
      count_next                  = count - CW'(1);
      result_next.popped_value    = data[0].value;
      result_next.popped_priority = data[0].prio;
    end
    if (take && (cmd.opcode == ssq_pkg::OP_PUSH) && is_full) begin
      result_next.status = ssq_pkg::ST_FULL;
    end else if (take && (cmd.opcode == ssq_pkg::OP_POP) && is_empty) begin
      result_next.status = ssq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= take;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    take && (cmd.opcode == ssq_pkg::OP_PUSH) && is_full
    |=> done && (result.status == ssq_pkg::ST_FULL) && $stable(count))
    else $error("push on full not reported or queue changed");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> (count == $past(count) - CW'(1)))
    else $error("pop did not shrink queue");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ssq_pkg::ST_OK)
    |-> (result.popped_value == '0) && (result.popped_priority == '0))
    else $error("failed word carries data");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    !take |=> !done)
    else $error("result word without command");
`endif

endmodule
